### hdl/pcm_pkg.sv
// Shared types, constants and palette tables for the palette colour mapper.
// No dependencies; every other file of the block but pcm_checker refers to this package.
`default_nettype none
package pcm_pkg;

    // Default widths for the top-level parameters.
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCHEME     = 2'd0;
    localparam logic [1:0] CFG_RANGE_LOW  = 2'd1;
    localparam logic [1:0] CFG_RANGE_HIGH = 2'd2;

    // Colour scheme codes; the unused codes fall back to the custom ramp.
    typedef enum logic [2:0] {
        SCHEME_RAINBOW = 3'd0,
        SCHEME_HEAT    = 3'd1,
        SCHEME_COOL    = 3'd2,
        SCHEME_GRAY    = 3'd3,
        SCHEME_CUSTOM  = 3'd4
    } t_scheme;

    // One colour: element 0 is red, 1 is green, 2 is blue.
    typedef logic [2:0][7:0] t_rgb;

    // Outcome of the range check that bypasses the divider.
    typedef struct packed {
        logic zero;   // sample at or below the start of the range
        logic one;    // sample at or beyond the end of the range
    } t_nflag;

    function automatic t_rgb mk_rgb(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
        mk_rgb = {b, g, r};
    endfunction

    // Index of the last palette entry for the interpolated schemes.
    function automatic logic [2:0] pal_last(input t_scheme scheme);
        logic [2:0] last;
        unique case (scheme)
            SCHEME_RAINBOW: last = 3'd6;
            SCHEME_HEAT:    last = 3'd5;
            SCHEME_COOL:    last = 3'd2;
            default:        last = 3'd0;
        endcase
        return last;
    endfunction

    // Palette entry lookup.
    function automatic t_rgb pal_color(input t_scheme scheme, input logic [2:0] idx);
        t_rgb c;
        c = '0;
        unique case (scheme)
            SCHEME_RAINBOW: begin
                case (idx)
                    3'd0:    c = mk_rgb(8'd255, 8'd0,   8'd0);
                    3'd1:    c = mk_rgb(8'd255, 8'd127, 8'd0);
                    3'd2:    c = mk_rgb(8'd255, 8'd255, 8'd0);
                    3'd3:    c = mk_rgb(8'd0,   8'd255, 8'd0);
                    3'd4:    c = mk_rgb(8'd0,   8'd0,   8'd255);
                    3'd5:    c = mk_rgb(8'd75,  8'd0,   8'd130);
                    default: c = mk_rgb(8'd148, 8'd0,   8'd211);
                endcase
            end
            SCHEME_HEAT: begin
                case (idx)
                    3'd0:    c = mk_rgb(8'd0,   8'd0,   8'd255);
                    3'd1:    c = mk_rgb(8'd0,   8'd255, 8'd255);
                    3'd2:    c = mk_rgb(8'd0,   8'd255, 8'd0);
                    3'd3:    c = mk_rgb(8'd255, 8'd255, 8'd0);
                    3'd4:    c = mk_rgb(8'd255, 8'd127, 8'd0);
                    default: c = mk_rgb(8'd255, 8'd0,   8'd0);
                endcase
            end
            SCHEME_COOL: begin
                case (idx)
                    3'd0:    c = mk_rgb(8'd0,   8'd255, 8'd255);
                    3'd1:    c = mk_rgb(8'd0,   8'd0,   8'd255);
                    default: c = mk_rgb(8'd128, 8'd0,   8'd128);
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### hdl/pcm_norm.sv
// Range normalisation front end: forms numerator and denominator of the
// position of a sample in the configured range. Depends on pcm_pkg.
`default_nettype none
module pcm_norm #(
    parameter int SAMPLE_BITS = pcm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [SAMPLE_BITS-1:0] i_range_low,
    input  wire logic [SAMPLE_BITS-1:0] i_range_high,
    output logic                        o_valid,
    output pcm_pkg::t_nflag             o_flag,
    output logic [SAMPLE_BITS-1:0]      o_num,
    output logic [SAMPLE_BITS-1:0]      o_den
);

    localparam int S = SAMPLE_BITS;

    logic                 r_v1;
    logic signed [S:0]    r_num1;
    logic signed [S:0]    r_den1;
    logic signed [S:0]    n_num1;
    logic signed [S:0]    n_den1;

    logic                 r_v2;
    pcm_pkg::t_nflag      r_flag2;
    logic [S-1:0]         r_num2;
    logic [S-1:0]         r_den2;
    logic signed [S:0]    v_den_nz;
    logic signed [S:0]    v_num_a;
    logic signed [S:0]    v_den_a;
    pcm_pkg::t_nflag      n_flag2;

    // First stage: exact differences against the lower bound.
    always_comb begin
        n_num1 = $signed({i_sample[S-1], i_sample}) - $signed({i_range_low[S-1], i_range_low});
        n_den1 = $signed({i_range_high[S-1], i_range_high})
               - $signed({i_range_low[S-1], i_range_low});
    end

    // Second stage: equal bounds, reversed bounds and the two saturated ends.
    always_comb begin
        v_den_nz = (r_den1 == '0) ? (S+1)'(1) : r_den1;
        v_num_a  = r_den1[S] ? -r_num1 : r_num1;
        v_den_a  = r_den1[S] ? -v_den_nz : v_den_nz;
        n_flag2.zero = (v_num_a <= 0);
        n_flag2.one  = (v_num_a >= v_den_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num1  <= n_num1;
            r_den1  <= n_den1;
            r_flag2 <= n_flag2;
            r_num2  <= v_num_a[S-1:0];
            r_den2  <= v_den_a[S-1:0];
        end
    end

    assign o_valid = r_v2;
    assign o_flag  = r_flag2;
    assign o_num   = r_num2;
    assign o_den   = r_den2;

endmodule
`default_nettype wire

### hdl/pcm_div.sv
// Pipelined restoring divider: one quotient bit per register stage, giving
// the fraction num/den in FRACTION_BITS bits for num below den. Uses pcm_pkg.
`default_nettype none
module pcm_div #(
    parameter int SAMPLE_BITS   = pcm_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = pcm_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire pcm_pkg::t_nflag          i_flag,
    input  wire logic [SAMPLE_BITS-1:0]   i_num,
    input  wire logic [SAMPLE_BITS-1:0]   i_den,
    output logic                          o_valid,
    output pcm_pkg::t_nflag               o_flag,
    output logic [FRACTION_BITS-1:0]      o_quo
);

    localparam int S = SAMPLE_BITS;
    localparam int F = FRACTION_BITS;

    logic [F-1:0]    r_vld;
    logic [S-1:0]    r_rem  [F];
    logic [S-1:0]    r_den  [F];
    logic [F-1:0]    r_quo  [F];
    pcm_pkg::t_nflag r_flag [F];

    logic [F-1:0]    s_vld;
    logic [S-1:0]    s_rem  [F];
    logic [S-1:0]    s_den  [F];
    logic [F-1:0]    s_quo  [F];
    pcm_pkg::t_nflag s_flag [F];

    logic [S-1:0]    n_rem  [F];
    logic [F-1:0]    n_quo  [F];
    logic [S:0]      v_sh   [F];
    logic [S:0]      v_sub  [F];
    logic [F-1:0]    v_ge;

    // Stage inputs: the first stage takes the new item, the others their predecessor.
    always_comb begin
        s_vld[0]  = i_valid;
        s_rem[0]  = i_num;
        s_den[0]  = i_den;
        s_quo[0]  = '0;
        s_flag[0] = i_flag;
        for (int k = 1; k < F; k++) begin
            s_vld[k]  = r_vld[k-1];
            s_rem[k]  = r_rem[k-1];
            s_den[k]  = r_den[k-1];
            s_quo[k]  = r_quo[k-1];
            s_flag[k] = r_flag[k-1];
        end
    end

    // Each stage doubles the partial remainder and subtracts the divisor if it fits.
    always_comb begin
        for (int k = 0; k < F; k++) begin
            v_sh[k]  = {s_rem[k], 1'b0};
            v_sub[k] = v_sh[k] - {1'b0, s_den[k]};
            v_ge[k]  = (v_sh[k] >= {1'b0, s_den[k]});
            n_rem[k] = v_ge[k] ? v_sub[k][S-1:0] : v_sh[k][S-1:0];
            n_quo[k] = {s_quo[k][F-2:0], v_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_den  <= s_den;
            r_quo  <= n_quo;
            r_flag <= s_flag;
        end
    end

    assign o_valid = r_vld[F-1];
    assign o_flag  = r_flag[F-1];
    assign o_quo   = r_quo[F-1];

endmodule
`default_nettype wire

### hdl/pcm_shade.sv
// Colour stages: palette lookup, per-channel interpolation products and the
// final blend or ramp selection, three register stages. Uses pcm_pkg.
`default_nettype none
module pcm_shade #(
    parameter int FRACTION_BITS = pcm_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire pcm_pkg::t_scheme         i_scheme,
    input  wire logic                     i_valid,
    input  wire pcm_pkg::t_nflag          i_flag,
    input  wire logic [FRACTION_BITS-1:0] i_quo,
    output logic                          o_valid,
    output pcm_pkg::t_rgb                 o_rgb
);

    localparam int F = FRACTION_BITS;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    // Stage A: fraction, palette index and the two neighbouring colours.
    logic [F:0]           v_n;
    logic [2:0]           v_last;
    logic [F+3:0]         v_t;
    logic [2:0]           v_idx;
    logic                 v_top;
    logic                 r_a_vld;
    logic [F:0]           r_a_n;
    logic [F-1:0]         r_a_frac;
    pcm_pkg::t_rgb        r_a_pa;
    pcm_pkg::t_rgb        r_a_pb;

    always_comb begin
        if (i_flag.one) begin
            v_n = ONE;
        end else if (i_flag.zero) begin
            v_n = '0;
        end else begin
            v_n = {1'b0, i_quo};
        end
        v_last = pcm_pkg::pal_last(i_scheme);
        v_t    = {3'b000, v_n} * {{(F+1){1'b0}}, v_last};
        v_idx  = v_t[F+2:F];
        v_top  = (v_t[F+3:F] >= {1'b0, v_last});
    end

    // Stage B: signed colour differences times the fraction, and the ramp products.
    logic signed [8:0]    v_diff [3];
    logic signed [F+9:0]  n_prod [3];
    logic [F+8:0]         v_gray;
    logic [F+8:0]         v_inv;
    logic [F:0]           v_rest;
    logic                 r_b_vld;
    pcm_pkg::t_rgb        r_b_a;
    logic signed [F+9:0]  r_b_prod [3];
    logic [F+7:0]         r_b_gray;
    logic [F+7:0]         r_b_inv;
    logic [F:0]           r_b_n;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            v_diff[ch] = $signed({1'b0, r_a_pb[ch]}) - $signed({1'b0, r_a_pa[ch]});
            n_prod[ch] = v_diff[ch] * $signed({1'b0, r_a_frac});
        end
        v_rest = ONE - r_a_n;
        v_gray = {r_a_n, 8'h00} - {8'h00, r_a_n};
        v_inv  = {v_rest, 8'h00} - {8'h00, v_rest};
    end

    // Stage C: blend sums and selection by scheme.
    logic signed [F+9:0]  v_acc [3];
    pcm_pkg::t_rgb        v_blend;
    pcm_pkg::t_rgb        n_rgb;
    logic                 r_c_vld;
    pcm_pkg::t_rgb        r_c_rgb;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            v_acc[ch]   = $signed({2'b00, r_b_a[ch], {F{1'b0}}}) + r_b_prod[ch];
            v_blend[ch] = v_acc[ch][F+7:F];
        end
        case (i_scheme) inside
            pcm_pkg::SCHEME_RAINBOW, pcm_pkg::SCHEME_HEAT, pcm_pkg::SCHEME_COOL: begin
                n_rgb = v_blend;
            end
            pcm_pkg::SCHEME_GRAY: begin
                n_rgb = {r_b_gray[F+7:F], r_b_gray[F+7:F], r_b_gray[F+7:F]};
            end
            default: begin
                n_rgb = {r_b_n[F:F-7], r_b_inv[F+7:F], r_b_gray[F+7:F]};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_n    <= v_n;
            r_a_frac <= v_top ? '0 : v_t[F-1:0];
            r_a_pa   <= pcm_pkg::pal_color(i_scheme, v_top ? v_last : v_idx);
            r_a_pb   <= pcm_pkg::pal_color(i_scheme, v_top ? v_last : 3'(v_idx + 3'd1));
            r_b_a    <= r_a_pa;
            r_b_prod <= n_prod;
            r_b_gray <= v_gray[F+7:0];
            r_b_inv  <= v_inv[F+7:0];
            r_b_n    <= r_a_n;
            r_c_rgb  <= n_rgb;
        end
    end

    assign o_valid = r_c_vld;
    assign o_rgb   = r_c_rgb;

endmodule
`default_nettype wire

### hdl/pcm_skid.sv
// Output register with a one-entry skid buffer; its fill state stalls the
// pipeline. Uses pcm_pkg for the colour type.
`default_nettype none
module pcm_skid (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire pcm_pkg::t_rgb  i_rgb,
    input  wire logic           i_ready,
    output logic                o_en,
    output logic                o_valid,
    output pcm_pkg::t_rgb       o_rgb
);

    logic          r_out_vld;
    logic          r_skid_vld;
    pcm_pkg::t_rgb r_out_rgb;
    pcm_pkg::t_rgb r_skid_rgb;

    // Control: the skid entry fills when a result arrives while the output is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_valid) begin
            if (r_out_vld && !i_ready) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Data: the output register takes either the skid entry or the new result.
    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_ready) begin
                r_out_rgb <= r_skid_rgb;
            end
        end else if (i_valid) begin
            if (r_out_vld && !i_ready) begin
                r_skid_rgb <= i_rgb;
            end else begin
                r_out_rgb <= i_rgb;
            end
        end
    end

    assign o_en    = !r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_rgb   = r_out_rgb;

endmodule
`default_nettype wire

### hdl/palette_color_mapper_top.sv
// Top level of the palette colour mapper: configuration registers and the
// pipeline pcm_norm, pcm_div, pcm_shade and pcm_skid. Uses pcm_pkg.
//
// Usage: signed samples arrive on the slave stream (s_axis), one per
// transaction, and each yields exactly one RGB colour on the master stream
// (m_axis), in order. The colour scheme and the range bounds are written
// through the plain write port (i_cfg_wr_en, i_cfg_index, i_cfg_data) while
// no sample is in flight: a user's duty that the block does not enforce.
// Throughput: one sample per clock while no stall holds the pipeline. The
// accepting edge loads the first of FRACTION_BITS + 6 register stages: two
// range stages, one divider stage per fraction bit, three colour stages and
// the output register.
// Reset: synchronous and active low; it empties the pipeline and sets the
// rainbow scheme with the range 0 to the largest positive sample.
// Stall: when the receiver holds i_m_axis_tready low, one more result is
// caught in a skid entry; after that o_s_axis_tready drops and the whole
// pipeline freezes without losing or repeating any transaction.
`default_nettype none
module palette_color_mapper_top #(
    parameter int SAMPLE_BITS   = pcm_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = pcm_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // tdata: sample in the lowest bits, zero padding above.
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // tdata: red [7:0], green [15:8], blue [23:16].
    output logic [23:0]                             o_m_axis_tdata,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [1:0]                         i_cfg_index,
    input  wire logic [SAMPLE_BITS-1:0]             i_cfg_data
);

    localparam int S = SAMPLE_BITS;
    localparam logic [S-1:0] HIGH_RESET = {1'b0, {(S-1){1'b1}}};

    pcm_pkg::t_scheme r_scheme;
    logic [S-1:0]     r_range_low;
    logic [S-1:0]     r_range_high;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme     <= pcm_pkg::SCHEME_RAINBOW;
            r_range_low  <= '0;
            r_range_high <= HIGH_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                pcm_pkg::CFG_SCHEME:     r_scheme     <= pcm_pkg::t_scheme'(i_cfg_data[2:0]);
                pcm_pkg::CFG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                pcm_pkg::CFG_RANGE_HIGH: r_range_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic            w_en;
    logic            w_norm_vld;
    pcm_pkg::t_nflag w_norm_flag;
    logic [S-1:0]    w_norm_num;
    logic [S-1:0]    w_norm_den;
    logic            w_div_vld;
    pcm_pkg::t_nflag w_div_flag;
    logic [FRACTION_BITS-1:0] w_div_quo;
    logic            w_shade_vld;
    pcm_pkg::t_rgb   w_shade_rgb;
    pcm_pkg::t_rgb   w_out_rgb;

    assign o_s_axis_tready = w_en;

    pcm_norm #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_norm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_s_axis_tvalid),
        .i_sample     (i_s_axis_tdata[S-1:0]),
        .i_range_low  (r_range_low),
        .i_range_high (r_range_high),
        .o_valid      (w_norm_vld),
        .o_flag       (w_norm_flag),
        .o_num        (w_norm_num),
        .o_den        (w_norm_den)
    );

    pcm_div #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_norm_vld),
        .i_flag  (w_norm_flag),
        .i_num   (w_norm_num),
        .i_den   (w_norm_den),
        .o_valid (w_div_vld),
        .o_flag  (w_div_flag),
        .o_quo   (w_div_quo)
    );

    pcm_shade #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_shade (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_scheme (r_scheme),
        .i_valid  (w_div_vld),
        .i_flag   (w_div_flag),
        .i_quo    (w_div_quo),
        .o_valid  (w_shade_vld),
        .o_rgb    (w_shade_rgb)
    );

    pcm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_shade_vld),
        .i_rgb   (w_shade_rgb),
        .i_ready (i_m_axis_tready),
        .o_en    (w_en),
        .o_valid (o_m_axis_tvalid),
        .o_rgb   (w_out_rgb)
    );

    assign o_m_axis_tdata = w_out_rgb;

endmodule
`default_nettype wire

### hdl/pcm_checker.sv
// Port-level checker for the palette colour mapper and the bind that
// attaches it to palette_color_mapper_top. No package dependency.
`default_nettype none
module pcm_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tready,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata
);

    // Nothing is offered to the receiver in the cycle after a reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("pcm: output valid after reset");

    // A stalled transaction stays offered with the same colour.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("pcm: stalled output changed");

    // Input back-pressure only occurs while a result is waiting at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_s_tready |-> i_m_tvalid)
        else $error("pcm: input stalled with empty output");

    // Once a waiting result is taken, the skid entry drains and input resumes.
    a_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_s_tready && i_m_tvalid && i_m_tready |=> i_s_tready && i_m_tvalid)
        else $error("pcm: input did not resume after drain");

endmodule

bind palette_color_mapper_top pcm_checker u_pcm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);
`default_nettype wire
